@@ hw/rtl/moe_expert_saliency_accumulator_defines.svh @@
// Assertion macros shared by the checker files.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef MOE_EXPERT_SALIENCY_ACCUMULATOR_DEFINES_SVH
`define MOE_EXPERT_SALIENCY_ACCUMULATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MSA_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define MSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ hw/rtl/msa_pkg.sv @@
// Shared types and constants of the expert saliency accumulator.
// Depends on nothing.
package msa_pkg;

  localparam int unsigned CountW  = 32;
  localparam int unsigned GateW   = 48;
  localparam int unsigned NormW   = 56;
  localparam int unsigned WsumW   = 64;
  localparam int unsigned TokW    = 40;
  localparam int unsigned SqSumW  = 48;
  localparam int unsigned RootW   = 24;
  localparam int unsigned ProdW   = 40;

  // Longest output vector; the square sum saturates at SqSumW whatever the length.
  localparam int unsigned VectorMax = 8192;

  localparam logic FUNC_ACC  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef struct packed {
    logic [CountW-1:0] count;
    logic [GateW-1:0]  gate_sum;
    logic [NormW-1:0]  norm_sum;
    logic [WsumW-1:0]  wsum;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

endpackage

@@ hw/rtl/msa_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
// Depends on nothing.
module msa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/msa_isqrt.sv @@
// Iterative integer square root, two radicand bits per cycle.
// Depends on msa_pkg for the radicand and root widths.
module msa_isqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [msa_pkg::SqSumW-1:0] value_i,
  output logic                       done_o,
  output logic [msa_pkg::RootW-1:0]  root_o
);
  import msa_pkg::*;

  localparam int unsigned IterW = $clog2(RootW + 1);

  logic [SqSumW-1:0] val_q, val_d;
  logic [RootW+1:0]  rem_q, rem_d;
  logic [RootW-1:0]  root_q, root_d;
  logic [IterW-1:0]  iter_q, iter_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [RootW+1:0]  rem_sh;
  logic [RootW+1:0]  trial;

  always_comb begin
    rem_sh = {rem_q[RootW-1:0], val_q[SqSumW-1 -: 2]};
    trial  = {root_q, 2'b01};
    val_d  = val_q;
    rem_d  = rem_q;
    root_d = root_q;
    iter_d = iter_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      val_d  = value_i;
      rem_d  = '0;
      root_d = '0;
      iter_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      val_d = {val_q[SqSumW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_d  = rem_sh - trial;
        root_d = {root_q[RootW-2:0], 1'b1};
      end else begin
        rem_d  = rem_sh;
        root_d = {root_q[RootW-2:0], 1'b0};
      end
      iter_d = iter_q + 1'b1;
      if (iter_q == IterW'(RootW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

@@ hw/rtl/moe_expert_saliency_accumulator.sv @@
// Channel   | valid / stall          | payload
// input     | in_valid_i / in_stall_o | func, layer, expert_id, gate_wt, out_value, ...
// output    | out_valid_o / out_stall_i | read_ok, activation_count, ..., token_count
// config    | cfg_we_i               | cfg_wdata_i (num_experts)
// A read or accumulate beat passes through S_SQ and S_ACC; a last-element beat
// goes on through S_ROOT, on the 24-step square root unit, then S_MUL and S_WR.
// After reset a clearing pass over all LAYERS*EXPERTS entries zeroes the tables; no
// beat is taken until it ends. A stalled result waits in the output register;
// a read beat behind it holds in its last step until that register frees.
// Depends on msa_pkg, msa_ram and msa_isqrt.
module moe_expert_saliency_accumulator #(
  parameter int unsigned EXPERTS    = 256,
  parameter int unsigned LAYERS     = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [8:0]                 cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       func_i,
  input  logic [5:0]                 layer_i,
  input  logic signed [8:0]          expert_id_i,
  input  logic [15:0]                gate_wt_i,
  input  logic signed [15:0]         out_value_i,
  input  logic                       last_element_i,
  input  logic                       token_start_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       read_ok_o,
  output logic [msa_pkg::CountW-1:0] activation_count_o,
  output logic [msa_pkg::GateW-1:0]  gate_wt_sum_o,
  output logic [msa_pkg::NormW-1:0]  norm_sum_o,
  output logic [msa_pkg::WsumW-1:0]  weighted_norm_sum_o,
  output logic [msa_pkg::TokW-1:0]   token_count_o
);
  import msa_pkg::*;

  localparam int unsigned Entries = LAYERS * EXPERTS;
  localparam int unsigned AddrW   = $clog2(Entries);
  localparam int unsigned TAddrW  = (LAYERS > 1) ? $clog2(LAYERS) : 1;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_SQ, S_ACC, S_ROOT, S_MUL, S_WR} state_e;

  state_e             state_q, state_d;
  logic [AddrW-1:0]   clr_q, clr_d;
  logic [8:0]         num_exp_q;
  logic [SqSumW-1:0]  ssum_q, ssum_d;

  logic               func_q, last_q, tstart_q, ok_q, lok_q;
  logic [AddrW-1:0]   idx_q;
  logic [5:0]         layer_q;
  logic [15:0]        gate_q, val_q;
  logic [31:0]        sq_q;
  logic [RootW-1:0]   norm_q;
  logic [ProdW-1:0]   prod_q;

  logic               out_valid_q;
  logic               rok_q;
  entry_t             rent_q;
  logic [TokW-1:0]    rtok_q;

  logic               accept, id_ok, lay_ok;
  logic [AddrW-1:0]   idx_in;
  logic [15:0]        mag;
  logic [SqSumW:0]    ssum_add;
  logic [SqSumW-1:0]  ssum_new;
  logic               out_free, load_out;

  logic               ent_we, ent_re, tok_we, tok_re;
  logic [AddrW-1:0]   ent_waddr;
  logic [TAddrW-1:0]  tok_waddr;
  entry_t             ent_wdata, ent_rdata, ent_upd;
  logic [TokW-1:0]    tok_wdata, tok_rdata;

  logic               sqrt_start, sqrt_done;
  logic [RootW-1:0]   sqrt_root;

  logic [GateW:0]     gate_add;
  logic [NormW:0]     norm_add;
  logic [WsumW:0]     wsum_add;

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  assign lay_ok = (32'(layer_i) < LAYERS);
  assign id_ok  = !expert_id_i[8] && ({1'b0, expert_id_i[7:0]} < num_exp_q)
                  && (32'(expert_id_i[7:0]) < EXPERTS);
  assign idx_in = AddrW'(32'(layer_i) * EXPERTS + 32'(expert_id_i[7:0]));

  assign mag      = val_q[15] ? 16'(16'd0 - val_q) : val_q;
  assign ssum_add = {1'b0, ssum_q} + (SqSumW + 1)'(sq_q);
  assign ssum_new = ssum_add[SqSumW] ? {SqSumW{1'b1}} : ssum_add[SqSumW-1:0];

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_out = (state_q == S_ACC) && (func_q == FUNC_READ) && out_free;

  // Saturating entry update.
  always_comb begin
    gate_add = {1'b0, ent_rdata.gate_sum} + (GateW + 1)'(gate_q);
    norm_add = {1'b0, ent_rdata.norm_sum} + (NormW + 1)'(norm_q);
    wsum_add = {1'b0, ent_rdata.wsum} + (WsumW + 1)'(prod_q);
    ent_upd.count    = (&ent_rdata.count) ? ent_rdata.count : ent_rdata.count + 1'b1;
    ent_upd.gate_sum = gate_add[GateW] ? {GateW{1'b1}} : gate_add[GateW-1:0];
    ent_upd.norm_sum = norm_add[NormW] ? {NormW{1'b1}} : norm_add[NormW-1:0];
    ent_upd.wsum     = wsum_add[WsumW] ? {WsumW{1'b1}} : wsum_add[WsumW-1:0];
  end

  always_comb begin
    ent_re    = (state_q == S_SQ);
    tok_re    = (state_q == S_SQ);
    ent_we    = 1'b0;
    tok_we    = 1'b0;
    ent_waddr = idx_q;
    ent_wdata = ent_upd;
    tok_waddr = TAddrW'(layer_q);
    tok_wdata = (&tok_rdata) ? tok_rdata : tok_rdata + 1'b1;
    if (state_q == S_CLR) begin
      ent_we    = 1'b1;
      ent_waddr = clr_q;
      ent_wdata = '0;
      tok_we    = (32'(clr_q) < LAYERS);
      tok_waddr = TAddrW'(clr_q);
      tok_wdata = '0;
    end else if (state_q == S_ACC) begin
      tok_we = (func_q == FUNC_ACC) && tstart_q && lok_q;
    end else if (state_q == S_WR) begin
      ent_we = ok_q;
    end
  end

  assign sqrt_start = (state_q == S_ACC) && (func_q == FUNC_ACC) && last_q;

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    ssum_d  = ssum_q;
    case (state_q)
      S_CLR: begin
        clr_d = clr_q + 1'b1;
        if (32'(clr_q) == Entries - 1) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) state_d = S_SQ;
      end
      S_SQ: state_d = S_ACC;
      S_ACC: begin
        if (func_q == FUNC_READ) begin
          if (out_free) state_d = S_IDLE;
        end else if (last_q) begin
          ssum_d  = '0;
          state_d = S_ROOT;
        end else begin
          ssum_d  = ssum_new;
          state_d = S_IDLE;
        end
      end
      S_ROOT: begin
        if (sqrt_done) state_d = S_MUL;
      end
      S_MUL: state_d = S_WR;
      S_WR: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      num_exp_q   <= 9'd128;
      ssum_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ssum_q  <= ssum_d;
      if (cfg_we_i) num_exp_q <= cfg_wdata_i;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q   <= func_i;
      layer_q  <= layer_i;
      idx_q    <= idx_in;
      ok_q     <= lay_ok && id_ok;
      lok_q    <= lay_ok;
      gate_q   <= gate_wt_i;
      val_q    <= out_value_i;
      last_q   <= last_element_i;
      tstart_q <= token_start_i;
    end
    if (state_q == S_SQ) sq_q <= mag * mag;
    if (sqrt_done) norm_q <= sqrt_root;
    if (state_q == S_MUL) prod_q <= gate_q * norm_q;
    if (load_out) begin
      rok_q  <= ok_q;
      rent_q <= ok_q ? ent_rdata : '0;
      rtok_q <= lok_q ? tok_rdata : '0;
    end
  end

  msa_ram #(.Width(EntryW), .Depth(Entries), .AddrW(AddrW)) u_ent_ram (
    .clk_i   (clk_i),
    .we_i    (ent_we),
    .waddr_i (ent_waddr),
    .wdata_i (ent_wdata),
    .re_i    (ent_re),
    .raddr_i (idx_q),
    .rdata_o (ent_rdata)
  );

  msa_ram #(.Width(TokW), .Depth(LAYERS), .AddrW(TAddrW)) u_tok_ram (
    .clk_i   (clk_i),
    .we_i    (tok_we),
    .waddr_i (tok_waddr),
    .wdata_i (tok_wdata),
    .re_i    (tok_re),
    .raddr_i (TAddrW'(layer_q)),
    .rdata_o (tok_rdata)
  );

  msa_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sqrt_start),
    .value_i (ssum_new),
    .done_o  (sqrt_done),
    .root_o  (sqrt_root)
  );

  assign out_valid_o         = out_valid_q;
  assign read_ok_o           = rok_q;
  assign activation_count_o  = rent_q.count;
  assign gate_wt_sum_o       = rent_q.gate_sum;
  assign norm_sum_o          = rent_q.norm_sum;
  assign weighted_norm_sum_o = rent_q.wsum;
  assign token_count_o       = rtok_q;

endmodule

@@ hw/rtl/msa_checker.sv @@
// Port-level checks of the saliency accumulator, bound to the top level.
// Depends on msa_pkg and moe_expert_saliency_accumulator_defines.svh.
`include "moe_expert_saliency_accumulator_defines.svh"

module msa_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       func_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic                       read_ok_o,
  input logic [msa_pkg::CountW-1:0] activation_count_o,
  input logic [msa_pkg::GateW-1:0]  gate_wt_sum_o,
  input logic [msa_pkg::NormW-1:0]  norm_sum_o
);
  import msa_pkg::*;

  // A stalled result beat stays put.
  `MSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
    out_valid_o && $stable(activation_count_o) && $stable(norm_sum_o))

  // A result for a skipped entry carries empty sums.
  `MSA_ASSERT_NOW(a_miss_zero, clk_i, rst_ni, out_valid_o && !read_ok_o,
    activation_count_o == '0 && gate_wt_sum_o == '0 && norm_sum_o == '0)

  // One beat at a time: the block is busy right after taking a beat.
  `MSA_ASSERT_NEXT(a_busy_after, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // An accumulate beat never raises a result.
  `MSA_ASSERT_NEXT(a_acc_silent, clk_i, rst_ni,
    in_valid_i && !in_stall_o && func_i == FUNC_ACC, !$rose(out_valid_o))

endmodule

bind moe_expert_saliency_accumulator msa_checker u_msa_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_stall_o         (in_stall_o),
  .func_i             (func_i),
  .out_valid_o        (out_valid_o),
  .out_stall_i        (out_stall_i),
  .read_ok_o          (read_ok_o),
  .activation_count_o (activation_count_o),
  .gate_wt_sum_o      (gate_wt_sum_o),
  .norm_sum_o         (norm_sum_o)
);

@@ dv/testbench.sv @@
// Testbench of the expert saliency accumulator: directed and random accumulate and read beats.
// A scoreboard predicts every read result. Depends on msa_pkg and the block.
module testbench;
  import msa_pkg::*;

  localparam int unsigned LimitCycles = 1000000;
  localparam int unsigned DrainCycles = 60;

  typedef struct {
    logic        func;
    logic [5:0]  layer;
    logic [8:0]  expert_id;
    logic [15:0] gate_wt;
    logic [15:0] out_value;
    logic        last_element;
    logic        token_start;
  } beat_t;

  typedef struct {
    logic              read_ok;
    logic [CountW-1:0] count;
    logic [GateW-1:0]  gate_sum;
    logic [NormW-1:0]  norm_sum;
    logic [WsumW-1:0]  wsum;
    logic [TokW-1:0]   tokens;
  } stats_t;

  class saliency_scoreboard;
    int unsigned       errors;
    logic [8:0]        num_experts;
    logic [SqSumW-1:0] square_sum;
    entry_t            entries[int];
    logic [TokW-1:0]   layer_tokens[64];
    stats_t            pending_reads[$];

    function new();
      errors = 0;
      num_experts = 9'd128;
      square_sum = '0;
      foreach (layer_tokens[i]) layer_tokens[i] = '0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b, int unsigned w);
      logic [64:0] s;
      logic [64:0] top;
      s = {1'b0, a} + {1'b0, b};
      top = (65'd1 << w) - 65'd1;
      return (s > top) ? top[63:0] : s[63:0];
    endfunction

    function logic [RootW-1:0] floor_root(logic [SqSumW-1:0] v);
      logic [RootW-1:0] r;
      logic [RootW-1:0] t;
      r = '0;
      for (int b = RootW - 1; b >= 0; b--) begin
        t = r | (24'd1 << b);
        if (64'(t) * 64'(t) <= 64'(v)) r = t;
      end
      return r;
    endfunction

    function bit id_valid(logic [8:0] id);
      return !id[8] && (id < num_experts);
    endfunction

    function void note_beat(beat_t b);
      int          key;
      entry_t      e;
      stats_t      r;
      logic [15:0] mag;
      logic [RootW-1:0] norm;
      key = int'({b.layer, b.expert_id[7:0]});
      if (b.func == FUNC_READ) begin
        r = '{default: '0};
        r.tokens = layer_tokens[b.layer];
        if (id_valid(b.expert_id)) begin
          e = entries.exists(key) ? entries[key] : '0;
          r.read_ok = 1'b1;
          r.count = e.count;
          r.gate_sum = e.gate_sum;
          r.norm_sum = e.norm_sum;
          r.wsum = e.wsum;
        end
        pending_reads.insert(pending_reads.size(), r);
        return;
      end
      if (b.token_start)
        layer_tokens[b.layer] = TokW'(sat_add(64'(layer_tokens[b.layer]), 64'd1, TokW));
      mag = b.out_value[15] ? 16'(-b.out_value) : b.out_value;
      square_sum = SqSumW'(sat_add(64'(square_sum), 64'(mag) * 64'(mag), SqSumW));
      if (b.last_element) begin
        norm = floor_root(square_sum);
        square_sum = '0;
        if (id_valid(b.expert_id)) begin
          e = entries.exists(key) ? entries[key] : '0;
          e.count = CountW'(sat_add(64'(e.count), 64'd1, CountW));
          e.gate_sum = GateW'(sat_add(64'(e.gate_sum), 64'(b.gate_wt), GateW));
          e.norm_sum = NormW'(sat_add(64'(e.norm_sum), 64'(norm), NormW));
          e.wsum = sat_add(e.wsum, 64'(b.gate_wt) * 64'(norm), WsumW);
          entries[key] = e;
        end
      end
    endfunction

    task check_result(stats_t got);
      stats_t want;
      if (pending_reads.size() == 0) begin
        report("result with no read outstanding");
        return;
      end
      want = pending_reads.pop_front();
      if (got.read_ok !== want.read_ok)
        report($sformatf("read_ok %0d want %0d", got.read_ok, want.read_ok));
      if (got.count !== want.count)
        report($sformatf("activation_count %0d want %0d", got.count, want.count));
      if (got.gate_sum !== want.gate_sum)
        report($sformatf("gate_wt_sum %0d want %0d", got.gate_sum, want.gate_sum));
      if (got.norm_sum !== want.norm_sum)
        report($sformatf("norm_sum %0d want %0d", got.norm_sum, want.norm_sum));
      if (got.wsum !== want.wsum)
        report($sformatf("weighted_norm_sum %0d want %0d", got.wsum, want.wsum));
      if (got.tokens !== want.tokens)
        report($sformatf("token_count %0d want %0d", got.tokens, want.tokens));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [8:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic func_i = 1'b0;
  logic [5:0] layer_i = '0;
  logic signed [8:0] expert_id_i = '0;
  logic [15:0] gate_wt_i = '0;
  logic signed [15:0] out_value_i = '0;
  logic last_element_i = 1'b0;
  logic token_start_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic read_ok_o;
  logic [CountW-1:0] activation_count_o;
  logic [GateW-1:0] gate_wt_sum_o;
  logic [NormW-1:0] norm_sum_o;
  logic [WsumW-1:0] weighted_norm_sum_o;
  logic [TokW-1:0] token_count_o;

  saliency_scoreboard sb = new();
  bit quiet = 1'b0;
  int unsigned cycles = 0;
  int unsigned stall_left = 0;

  moe_expert_saliency_accumulator i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .in_valid_i, .in_stall_o,
    .func_i, .layer_i, .expert_id_i, .gate_wt_i, .out_value_i,
    .last_element_i, .token_start_i, .out_valid_o, .out_stall_i,
    .read_ok_o, .activation_count_o, .gate_wt_sum_o, .norm_sum_o,
    .weighted_norm_sum_o, .token_count_o
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Take a result beat, then draw the stall before the next one.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      sb.check_result('{read_ok_o, activation_count_o, gate_wt_sum_o,
                        norm_sum_o, weighted_norm_sum_o, token_count_o});
      stall_left = quiet ? 0 : $urandom_range(0, 9);
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall_i <= (stall_left != 0);
  end

  task automatic send_beat(beat_t b);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= b.func;
    layer_i <= b.layer;
    expert_id_i <= b.expert_id;
    gate_wt_i <= b.gate_wt;
    out_value_i <= b.out_value;
    last_element_i <= b.last_element;
    token_start_i <= b.token_start;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(b);
  endtask

  // Hold off until the block is idle, then write the expert count.
  task automatic write_num_experts(logic [8:0] value);
    in_valid_i <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.num_experts = value;
  endtask

  task automatic send_read(logic [5:0] layer, logic [8:0] id, logic tstart);
    send_beat('{FUNC_READ, layer, id, 16'($urandom), 16'($urandom), 1'($urandom), tstart});
  endtask

  task automatic send_vector(logic [5:0] layer, logic [8:0] id, logic [15:0] gate, int len);
    logic [15:0] v;
    for (int i = 0; i < len; i++) begin
      v = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2047) - 1024);
      send_beat('{FUNC_ACC, layer, id, gate, v, i == len - 1,
                  (i == 0) ? 1'($urandom_range(0, 3) != 0) : 1'($urandom_range(0, 7) == 0)});
    end
  endtask

  function automatic logic [8:0] pick_id();
    case ($urandom_range(0, 9))
      0: return 9'($urandom);
      1: return sb.num_experts;
      2: return sb.num_experts - 9'd1;
      default: return 9'($urandom_range(0, 3));
    endcase
  endfunction

  function automatic logic [5:0] pick_layer();
    case ($urandom_range(0, 4))
      0: return 6'($urandom);
      1: return 6'd63;
      default: return 6'($urandom_range(0, 2));
    endcase
  endfunction

  initial begin
    logic [8:0] settings[6];
    logic [5:0] layer;
    logic [8:0] id;
    int unsigned sent;
    settings = '{9'd1, 9'd256, 9'd37, 9'd511, 9'd200, 9'd128};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: extremes of every field under the reset expert count.
    quiet = 1'b1;
    send_read(6'd0, 9'd0, 1'b1);
    send_beat('{FUNC_ACC, 6'd0, 9'd0, 16'hFFFF, 16'h8000, 1'b1, 1'b1});
    send_beat('{FUNC_ACC, 6'd63, 9'd127, 16'h0000, 16'h7FFF, 1'b0, 1'b1});
    send_beat('{FUNC_ACC, 6'd63, 9'd127, 16'h8001, 16'hFFFF, 1'b1, 1'b0});
    send_beat('{FUNC_ACC, 6'd5, 9'h100, 16'h1234, 16'h0100, 1'b1, 1'b1});
    send_beat('{FUNC_ACC, 6'd5, 9'd128, 16'h4321, 16'h0000, 1'b1, 1'b0});
    send_beat('{FUNC_ACC, 6'd5, 9'h1FF, 16'hFFFF, 16'h00FF, 1'b1, 1'b0});
    send_read(6'd0, 9'd0, 1'b0);
    send_read(6'd63, 9'd127, 1'b1);
    send_read(6'd5, 9'h100, 1'b0);
    send_read(6'd5, 9'd128, 1'b0);
    send_read(6'd5, 9'h1FF, 1'b0);
    send_read(6'd63, 9'd255, 1'b0);
    quiet = 1'b0;

    sent = 0;
    for (int phase = 0; phase < 6; phase++) begin
      write_num_experts(settings[phase]);
      quiet = (phase == 2);
      while (sent < (phase + 1) * 240) begin
        layer = pick_layer();
        id = pick_id();
        case ($urandom_range(0, 9))
          0: begin
            send_beat('{1'($urandom), 6'($urandom), 9'($urandom), 16'($urandom),
                        16'($urandom), 1'($urandom), 1'($urandom)});
            sent++;
          end
          1, 2, 3: begin
            send_read(layer, id, 1'($urandom));
            sent++;
          end
          default: begin
            int len;
            len = $urandom_range(1, 10);
            send_vector(layer, id, 16'($urandom), len);
            sent += len;
          end
        endcase
      end
    end

    in_valid_i <= 1'b0;
    while (sb.pending_reads.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
